/* hw/rtl/attribute_framebuffer_plotter_macros.svh */
// assertion macros used by the afb_back plotter module
// the asserting module provides clk_i and rst_ni
`ifndef ATTRIBUTE_FRAMEBUFFER_PLOTTER_MACROS_SVH
`define ATTRIBUTE_FRAMEBUFFER_PLOTTER_MACROS_SVH

// property that must hold at every clock edge outside reset
`define AFB_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// condition that must be followed by an outcome in the next cycle
`define AFB_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

/* hw/rtl/afb_pkg.sv */
package afb_pkg;

  // screen and store geometry
  localparam int AFB_SCREEN_W   = 256;
  localparam int AFB_SCREEN_H   = 192;
  localparam int AFB_PIX_DEPTH  = 6144;
  localparam int AFB_ATTR_DEPTH = 768;
  localparam int AFB_PIX_AW     = 13;
  localparam int AFB_ATTR_AW    = 10;
  localparam int AFB_CMDQ_DEPTH = 2;

  // attribute byte fields
  localparam logic [7:0] AFB_ATTR_KEEP = 8'hB8;  // flash and paper survive a plot
  localparam logic [2:0] AFB_CLR_INK   = 3'd7;

  // input mode codes
  localparam logic [1:0] MODE_PLOT  = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_CLEAR = 2'd2;
  localparam logic [1:0] MODE_FILL  = 2'd3;

  // command kinds after classification
  typedef enum logic [1:0] {
    OP_SKIP,   // nothing to do, result is zero
    OP_READ,   // read one pixel colour
    OP_CLEAR,  // sweep both stores
    OP_RECT    // plot an inclusive on-screen rectangle
  } afb_op_e;

  typedef struct packed {
    afb_op_e    op;
    logic [7:0] xl;
    logic [7:0] xr;
    logic [7:0] yt;
    logic [7:0] yb;
    logic [3:0] color;
  } afb_cmd_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_CLEAR,
    ST_DONE
  } afb_state_e;

  // interleaved bitmap address: third, pixel row, character row, byte column
  function automatic logic [AFB_PIX_AW-1:0] afb_pix_addr(input logic [7:0] row,
                                                         input logic [4:0] col);
    afb_pix_addr = {row[7:6], row[2:0], row[5:3], col};
  endfunction

  function automatic logic [AFB_ATTR_AW-1:0] afb_attr_addr(input logic [7:0] row,
                                                           input logic [4:0] col);
    afb_attr_addr = {row[7:3], col};
  endfunction

endpackage

/* hw/rtl/afb_front.sv */
module afb_front (
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic signed [9:0] x_i,
  input  logic signed [9:0] y_i,
  input  logic [8:0]        width_i,
  input  logic [8:0]        height_i,
  input  logic [3:0]        color_i,
  input  logic              q_full_i,
  input  logic              init_busy_i,
  output logic              q_push_o,
  output afb_pkg::afb_cmd_t q_cmd_o
);
  import afb_pkg::*;

  logic signed [10:0] x_s, y_s, x_end, y_end;
  logic signed [10:0] x_lo, y_lo, x_hi, y_hi, x_last, y_last;
  logic               pt_on, rect_empty;

  // handshake toward the queue
  assign in_stall_o = q_full_i || init_busy_i;
  assign q_push_o   = in_valid_i && !in_stall_o;

  // single pixel on screen
  assign pt_on = !x_i[9] && !x_i[8] && !y_i[9] && !y_i[8] && (y_i[7:6] != 2'b11);

  // rectangle clipping
  always_comb begin
    x_s    = {x_i[9], x_i};
    y_s    = {y_i[9], y_i};
    x_end  = x_s + $signed({2'b00, width_i});
    y_end  = y_s + $signed({2'b00, height_i});
    x_lo   = x_i[9] ? '0 : x_s;
    y_lo   = y_i[9] ? '0 : y_s;
    x_hi   = (x_end > $signed(11'(AFB_SCREEN_W))) ? $signed(11'(AFB_SCREEN_W)) : x_end;
    y_hi   = (y_end > $signed(11'(AFB_SCREEN_H))) ? $signed(11'(AFB_SCREEN_H)) : y_end;
    x_last = x_hi - 11'sd1;
    y_last = y_hi - 11'sd1;
    rect_empty = (x_hi <= x_lo) || (y_hi <= y_lo);
  end

  // classify the beat into a command
  always_comb begin
    q_cmd_o.op    = OP_SKIP;
    q_cmd_o.xl    = x_i[7:0];
    q_cmd_o.xr    = x_i[7:0];
    q_cmd_o.yt    = y_i[7:0];
    q_cmd_o.yb    = y_i[7:0];
    q_cmd_o.color = color_i;
    unique case (mode_i)
      MODE_PLOT: begin
        if (pt_on) q_cmd_o.op = OP_RECT;
      end
      MODE_READ: begin
        if (pt_on) q_cmd_o.op = OP_READ;
      end
      MODE_CLEAR: begin
        q_cmd_o.op = OP_CLEAR;
      end
      MODE_FILL: begin
        if (!rect_empty) q_cmd_o.op = OP_RECT;
        q_cmd_o.xl = x_lo[7:0];
        q_cmd_o.xr = x_last[7:0];
        q_cmd_o.yt = y_lo[7:0];
        q_cmd_o.yb = y_last[7:0];
      end
      default: ;
    endcase
  end

endmodule

/* hw/rtl/afb_cmdq.sv */
module afb_cmdq #(
  parameter int Depth = afb_pkg::AFB_CMDQ_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  afb_pkg::afb_cmd_t cmd_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output afb_pkg::afb_cmd_t cmd_o
);
  import afb_pkg::*;

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  afb_cmd_t        slot_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;

  assign valid_o = (cnt_q != '0);
  assign full_o  = (cnt_q == CntW'(Depth));
  assign cmd_o   = slot_q[rd_ptr_q];

  // pointer and count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    if (pop_i)  rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    if (push_i && !pop_i)      cnt_d = cnt_q + 1'b1;
    else if (!push_i && pop_i) cnt_d = cnt_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // slot storage
  always_ff @(posedge clk_i) begin
    if (push_i) slot_q[wr_ptr_q] <= cmd_i;
  end

endmodule

/* hw/rtl/afb_back.sv */
module afb_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  afb_pkg::afb_cmd_t q_cmd_i,
  output logic              q_pop_o,
  output logic              init_busy_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        pixel_color_o
);
  import afb_pkg::*;

  `include "attribute_framebuffer_plotter_macros.svh"

  afb_state_e state_q, state_d;
  afb_cmd_t   cmd_q, cmd_d;
  logic [4:0] wcol_q, wcol_d;
  logic [7:0] wrow_q, wrow_d;
  logic [AFB_PIX_AW-1:0] clr_cnt_q, clr_cnt_d;
  logic       clr_res_q, clr_res_d;
  logic [7:0] clr_val_q, clr_val_d;
  logic       out_valid_q, out_valid_d;
  logic [3:0] res_q, res_d, pend_q, pend_d;

  // memories
  logic [7:0] pix_mem  [AFB_PIX_DEPTH];
  logic [7:0] attr_mem [AFB_ATTR_DEPTH];
  logic [7:0] pix_rd_q, attr_rd_q;
  logic [AFB_PIX_AW-1:0]  pix_waddr;
  logic [AFB_ATTR_AW-1:0] attr_waddr;
  logic [7:0] pix_wdata, attr_wdata;
  logic       pix_we, attr_we;
  logic [4:0] rd_col;
  logic [7:0] rd_row;

  // walk and datapath helpers
  logic       out_free, col_end, walk_last, clr_last;
  logic [4:0] nxt_col;
  logic [7:0] nxt_row;
  logic [2:0] lo_bit, hi_bit;
  logic [7:0] byte_mask, plot_attr;
  logic       pix_bit;
  logic [3:0] read_color;
  logic       q_pop, load;
  logic [3:0] load_val;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign col_end     = (wcol_q == cmd_q.xr[7:3]);
  assign walk_last   = col_end && (wrow_q == cmd_q.yb);
  assign nxt_col     = col_end ? cmd_q.xl[7:3] : wcol_q + 5'd1;
  assign nxt_row     = col_end ? wrow_q + 8'd1 : wrow_q;
  assign clr_last    = (clr_cnt_q == AFB_PIX_AW'(AFB_PIX_DEPTH - 1));
  assign init_busy_o = (state_q == ST_CLEAR) && !clr_res_q;

  // pixel bits of the current byte that fall inside the rectangle
  assign lo_bit    = (wcol_q == cmd_q.xl[7:3]) ? cmd_q.xl[2:0] : 3'd0;
  assign hi_bit    = col_end ? cmd_q.xr[2:0] : 3'd7;
  assign byte_mask = (8'hFF >> lo_bit) & (8'hFF << (~hi_bit));
  assign plot_attr = (attr_rd_q & AFB_ATTR_KEEP) | {1'b0, cmd_q.color[3], 3'b000,
                                                    cmd_q.color[2:0]};

  // colour seen at the read pixel, leftmost pixel in bit 7
  assign pix_bit    = pix_rd_q[~cmd_q.xl[2:0]];
  assign read_color = {attr_rd_q[6], pix_bit ? attr_rd_q[2:0] : attr_rd_q[5:3]};

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          case (q_cmd_i.op)
            OP_SKIP:          state_d = out_free ? ST_IDLE : ST_DONE;
            OP_READ, OP_RECT: state_d = ST_WALK;
            OP_CLEAR:         state_d = ST_CLEAR;
            default:          state_d = ST_IDLE;
          endcase
        end
      end
      ST_WALK: begin
        if (cmd_q.op == OP_READ || walk_last) state_d = out_free ? ST_IDLE : ST_DONE;
      end
      ST_CLEAR: begin
        if (clr_last) state_d = (clr_res_q && !out_free) ? ST_DONE : ST_IDLE;
      end
      ST_DONE: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs and datapath controls
  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    load_val   = '0;
    pend_d     = pend_q;
    cmd_d      = cmd_q;
    wcol_d     = wcol_q;
    wrow_d     = wrow_q;
    clr_cnt_d  = clr_cnt_q;
    clr_res_d  = clr_res_q;
    clr_val_d  = clr_val_q;
    pix_we     = 1'b0;
    attr_we    = 1'b0;
    pix_waddr  = afb_pix_addr(wrow_q, wcol_q);
    attr_waddr = afb_attr_addr(wrow_q, wcol_q);
    pix_wdata  = pix_rd_q | byte_mask;
    attr_wdata = plot_attr;
    rd_col     = nxt_col;
    rd_row     = nxt_row;
    unique case (state_q)
      ST_IDLE: begin
        // take a command and issue the read of its first byte
        rd_col = q_cmd_i.xl[7:3];
        rd_row = q_cmd_i.yt;
        if (q_valid_i) begin
          q_pop  = 1'b1;
          cmd_d  = q_cmd_i;
          wcol_d = q_cmd_i.xl[7:3];
          wrow_d = q_cmd_i.yt;
          if (q_cmd_i.op == OP_SKIP) begin
            load   = out_free;
            pend_d = '0;
          end
          if (q_cmd_i.op == OP_CLEAR) begin
            clr_cnt_d = '0;
            clr_res_d = 1'b1;
            clr_val_d = {1'b0, q_cmd_i.color[3], q_cmd_i.color[2:0], AFB_CLR_INK};
          end
        end
      end
      ST_WALK: begin
        if (cmd_q.op == OP_READ) begin
          load     = out_free;
          load_val = read_color;
          pend_d   = read_color;
        end else begin
          // read of the next byte overlaps this write; a same-cell attribute
          // read returns the old byte, whose kept bits equal the new ones
          pix_we  = 1'b1;
          attr_we = 1'b1;
          wcol_d  = nxt_col;
          wrow_d  = nxt_row;
          if (walk_last) begin
            load   = out_free;
            pend_d = '0;
          end
        end
      end
      ST_CLEAR: begin
        pix_we     = 1'b1;
        pix_waddr  = clr_cnt_q;
        pix_wdata  = '0;
        attr_we    = (clr_cnt_q < AFB_PIX_AW'(AFB_ATTR_DEPTH));
        attr_waddr = clr_cnt_q[AFB_ATTR_AW-1:0];
        attr_wdata = clr_val_q;
        clr_cnt_d  = clr_cnt_q + 1'b1;
        if (clr_last && clr_res_q) begin
          load   = out_free;
          pend_d = '0;
        end
      end
      ST_DONE: begin
        load     = out_free;
        load_val = pend_q;
      end
      default: ;
    endcase
  end

  // result register
  always_comb begin
    out_valid_d = out_valid_q && out_stall_i;
    res_d       = res_q;
    if (load) begin
      out_valid_d = 1'b1;
      res_d       = load_val;
    end
  end

  assign q_pop_o       = q_pop;
  assign out_valid_o   = out_valid_q;
  assign pixel_color_o = res_q;

  // control registers, reset starts the store clearing sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      clr_res_q   <= 1'b0;
      clr_val_q   <= '0;
      out_valid_q <= 1'b0;
      wcol_q      <= '0;
      wrow_q      <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      clr_res_q   <= clr_res_d;
      clr_val_q   <= clr_val_d;
      out_valid_q <= out_valid_d;
      wcol_q      <= wcol_d;
      wrow_q      <= wrow_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    res_q  <= res_d;
    pend_q <= pend_d;
  end

  // bitmap store
  always_ff @(posedge clk_i) begin
    if (pix_we) pix_mem[pix_waddr] <= pix_wdata;
    pix_rd_q <= pix_mem[afb_pix_addr(rd_row, rd_col)];
  end

  // attribute store
  always_ff @(posedge clk_i) begin
    if (attr_we) attr_mem[attr_waddr] <= attr_wdata;
    attr_rd_q <= attr_mem[afb_attr_addr(rd_row, rd_col)];
  end

  // checks
  `AFB_ASSERT(a_pop_needs_cmd, q_pop |-> q_valid_i, "pop from an empty command queue")
  `AFB_ASSERT(a_no_pop_in_init, init_busy_o |-> !q_pop, "command taken during reset sweep")
  `AFB_ASSERT(a_load_when_free, load |-> out_free, "result register overwritten")
  `AFB_ASSERT(a_walk_in_rect, (state_q == ST_WALK && cmd_q.op == OP_RECT) |-> (wcol_q >= cmd_q.xl[7:3] && wcol_q <= cmd_q.xr[7:3] && wrow_q >= cmd_q.yt && wrow_q <= cmd_q.yb), "walk left the rectangle")
  `AFB_ASSERT_NEXT(a_clear_result, state_q == ST_CLEAR && clr_last && clr_res_q && out_free, state_q == ST_IDLE && out_valid_q, "clear finished without a result")

endmodule

/* hw/rtl/attribute_framebuffer_plotter.sv */
// channel  direction  handshake                  payload
// in       sink       in_valid_i / in_stall_o    mode_i x_i y_i width_i height_i color_i
// out      source     out_valid_o / out_stall_i  pixel_color_o
//
// plot and read each first read both stores, then write the byte or answer
// fill reads its first byte, then writes each bitmap byte that the clipped rectangle touches
// clear runs the sweep, one bitmap byte written per cycle
// after reset a sweep zeroes both stores while in_stall_o stays high
// a command queue and a result register let input and output stall independently
module attribute_framebuffer_plotter #(
  parameter int CmdqDepth = afb_pkg::AFB_CMDQ_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        mode_i,
  input  logic signed [9:0] x_i,
  input  logic signed [9:0] y_i,
  input  logic [8:0]        width_i,
  input  logic [8:0]        height_i,
  input  logic [3:0]        color_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic [3:0]        pixel_color_o
);
  import afb_pkg::*;

  afb_cmd_t push_cmd, head_cmd;
  logic     q_push, q_full, q_pop, q_valid, init_busy;

  // classify incoming beats
  afb_front u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .mode_i      (mode_i),
    .x_i         (x_i),
    .y_i         (y_i),
    .width_i     (width_i),
    .height_i    (height_i),
    .color_i     (color_i),
    .q_full_i    (q_full),
    .init_busy_i (init_busy),
    .q_push_o    (q_push),
    .q_cmd_o     (push_cmd)
  );

  // command queue
  afb_cmdq #(
    .Depth (CmdqDepth)
  ) u_cmdq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  // store engine
  afb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .q_valid_i     (q_valid),
    .q_cmd_i       (head_cmd),
    .q_pop_o       (q_pop),
    .init_busy_o   (init_busy),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .pixel_color_o (pixel_color_o)
  );

endmodule
